// ===== rtl/mvt_pkg.sv =====
// Shared constants, types and register codes for the 4x4 matrix-vector transform.
package mvt_pkg;

   localparam int DIM          = 4;
   localparam int COEF_WIDTH   = 16;
   localparam int FRAC_BITS    = 8;
   localparam int VEC_WIDTH    = 16;
   localparam int NUM_COMP     = 4;
   localparam int NUM_ROWS     = 4;
   localparam int ROW_WIDTH    = 64;
   localparam int CSR_IDX_WIDTH = 3;

   localparam int PROD_WIDTH = COEF_WIDTH + VEC_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH + $clog2(DIM) + 1;

   typedef logic [VEC_WIDTH-1:0]  comp_type;
   typedef logic [COEF_WIDTH-1:0] coef_type;
   typedef logic [ACC_WIDTH-1:0]  acc_type;
   typedef logic [ROW_WIDTH-1:0]  row_type;

   localparam acc_type ROUND_CONST = (ACC_WIDTH'(1) << FRAC_BITS) >> 1;
   localparam acc_type OUT_MAX     = ACC_WIDTH'(32767);
   localparam acc_type OUT_MIN     = -ACC_WIDTH'(32768);
   localparam row_type COEF_ONE    = ROW_WIDTH'(1) << FRAC_BITS;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_ROW_ZERO,
      CSR_ROW_ONE,
      CSR_ROW_TWO,
      CSR_ROW_THREE,
      CSR_ROW_VECTOR_MODE
   } csr_index_type;

   typedef struct packed {
      logic                       valid;
      comp_type [NUM_COMP-1:0]    vec;
      acc_type  [DIM-1:0]         sum;
   } cell_bus_type;

endpackage

// ===== rtl/mvt_cell.sv =====
// One multiply-accumulate cell: adds one matrix column times one vector component.
module mvt_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mvt_pkg::cell_bus_type                bus_in,
   input  mvt_pkg::coef_type [mvt_pkg::DIM-1:0] column,
   output mvt_pkg::cell_bus_type                bus_out
);

   logic signed [mvt_pkg::PROD_WIDTH-1:0]         prod [mvt_pkg::DIM];
   mvt_pkg::acc_type [mvt_pkg::DIM-1:0]           sum_in;
   mvt_pkg::acc_type [mvt_pkg::DIM-1:0]           sum_ff;
   mvt_pkg::comp_type [mvt_pkg::NUM_COMP-1:0]     vec_in;
   mvt_pkg::comp_type [mvt_pkg::NUM_COMP-1:0]     vec_ff;
   logic                                          valid_ff;

   always_comb begin
      for (int i = 0; i < mvt_pkg::DIM; i++) begin
         prod[i]   = $signed(column[i]) * $signed(bus_in.vec[0]);
         sum_in[i] = bus_in.sum[i] + mvt_pkg::ACC_WIDTH'(prod[i]);
      end
   end

   // The vector rotates so that every cell uses component zero.
   always_comb begin
      for (int k = 0; k < mvt_pkg::NUM_COMP - 1; k++) begin
         vec_in[k] = bus_in.vec[k+1];
      end
      vec_in[mvt_pkg::NUM_COMP-1] = bus_in.vec[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= bus_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      vec_ff <= vec_in;
   end

   assign bus_out.valid = valid_ff;
   assign bus_out.vec   = vec_ff;
   assign bus_out.sum   = sum_ff;

endmodule

// ===== rtl/mvt_sat.sv =====
// Output stage: drops the fraction bits, saturates to 16 bits and registers the result.
module mvt_sat (
   input  logic                                      clock,
   input  logic                                      reset,
   input  mvt_pkg::cell_bus_type                     bus_in,
   output logic                                      strobe,
   output mvt_pkg::comp_type [mvt_pkg::NUM_COMP-1:0] vout,
   output logic                                      clipped
);

   mvt_pkg::comp_type [mvt_pkg::NUM_COMP-1:0] vout_in;
   mvt_pkg::comp_type [mvt_pkg::NUM_COMP-1:0] vout_ff;
   logic [mvt_pkg::NUM_COMP-1:0]              clip_in;
   logic                                      clipped_ff;
   logic                                      strobe_ff;

   for (genvar i = 0; i < mvt_pkg::NUM_COMP; i++) begin : g_comp
      if (i < mvt_pkg::DIM) begin : g_used
         mvt_pkg::acc_type shifted;
         always_comb begin
            shifted = $signed(bus_in.sum[i]) >>> mvt_pkg::FRAC_BITS;
            if ($signed(shifted) > $signed(mvt_pkg::OUT_MAX)) begin
               vout_in[i] = mvt_pkg::OUT_MAX[mvt_pkg::VEC_WIDTH-1:0];
               clip_in[i] = 1'b1;
            end else if ($signed(shifted) < $signed(mvt_pkg::OUT_MIN)) begin
               vout_in[i] = mvt_pkg::OUT_MIN[mvt_pkg::VEC_WIDTH-1:0];
               clip_in[i] = 1'b1;
            end else begin
               vout_in[i] = shifted[mvt_pkg::VEC_WIDTH-1:0];
               clip_in[i] = 1'b0;
            end
         end
      end else begin : g_unused
         assign vout_in[i] = '0;
         assign clip_in[i] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= bus_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      vout_ff    <= vout_in;
      clipped_ff <= |clip_in;
   end

   assign strobe  = strobe_ff;
   assign vout    = vout_ff;
   assign clipped = clipped_ff;

endmodule

// ===== rtl/matrix_vector_transform_4x4.sv =====
// Top level of the 4x4 matrix-vector transform: register file, cell chain and output stage.
// One vector can be taken in every clock cycle while busy is low; its result appears on the
// rsp_ ports, marked by rsp_strobe, after it has passed the register of each of the DIM
// multiply-accumulate cells of the chain and the register of the rounding and saturation
// stage. The results arrive in order and are not held, so the
// receiver must take each one in the cycle it is shown. busy is high only during reset.
// The matrix rows and the mode must be written only while no transfer is in flight.
module matrix_vector_transform_4x4 (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [mvt_pkg::VEC_WIDTH-1:0]   req_vin_zero,
   input  logic signed [mvt_pkg::VEC_WIDTH-1:0]   req_vin_one,
   input  logic signed [mvt_pkg::VEC_WIDTH-1:0]   req_vin_two,
   input  logic signed [mvt_pkg::VEC_WIDTH-1:0]   req_vin_three,
   output logic                                   rsp_strobe,
   output logic signed [mvt_pkg::VEC_WIDTH-1:0]   rsp_vout_zero,
   output logic signed [mvt_pkg::VEC_WIDTH-1:0]   rsp_vout_one,
   output logic signed [mvt_pkg::VEC_WIDTH-1:0]   rsp_vout_two,
   output logic signed [mvt_pkg::VEC_WIDTH-1:0]   rsp_vout_three,
   output logic                                   rsp_clipped,
   input  logic                                   csr_write_enable,
   input  logic [mvt_pkg::CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [mvt_pkg::ROW_WIDTH-1:0]          csr_write_data
);

   mvt_pkg::row_type                                row_ff [mvt_pkg::NUM_ROWS];
   logic                                            mode_ff;
   mvt_pkg::coef_type [mvt_pkg::DIM-1:0]            column [mvt_pkg::DIM];
   mvt_pkg::cell_bus_type                           bus [mvt_pkg::DIM+1];
   mvt_pkg::comp_type [mvt_pkg::NUM_COMP-1:0]       vout;
   logic                                            accept;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < mvt_pkg::NUM_ROWS; r++) begin
            row_ff[r] <= mvt_pkg::COEF_ONE << (r * mvt_pkg::COEF_WIDTH);
         end
         mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (mvt_pkg::csr_index_type'(csr_index))
            mvt_pkg::CSR_ROW_ZERO:        row_ff[0] <= csr_write_data;
            mvt_pkg::CSR_ROW_ONE:         row_ff[1] <= csr_write_data;
            mvt_pkg::CSR_ROW_TWO:         row_ff[2] <= csr_write_data;
            mvt_pkg::CSR_ROW_THREE:       row_ff[3] <= csr_write_data;
            mvt_pkg::CSR_ROW_VECTOR_MODE: mode_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Column j of the effective matrix; row-vector mode uses the transpose.
   always_comb begin
      for (int j = 0; j < mvt_pkg::DIM; j++) begin
         for (int i = 0; i < mvt_pkg::DIM; i++) begin
            if (mode_ff) begin
               column[j][i] = row_ff[j][i*mvt_pkg::COEF_WIDTH +: mvt_pkg::COEF_WIDTH];
            end else begin
               column[j][i] = row_ff[i][j*mvt_pkg::COEF_WIDTH +: mvt_pkg::COEF_WIDTH];
            end
         end
      end
   end

   // The rounding constant enters as the initial partial sum.
   always_comb begin
      bus[0].valid  = accept;
      bus[0].vec[0] = req_vin_zero;
      bus[0].vec[1] = req_vin_one;
      bus[0].vec[2] = req_vin_two;
      bus[0].vec[3] = req_vin_three;
      for (int i = 0; i < mvt_pkg::DIM; i++) begin
         bus[0].sum[i] = mvt_pkg::ROUND_CONST;
      end
   end

   for (genvar j = 0; j < mvt_pkg::DIM; j++) begin : g_cell
      mvt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .bus_in  (bus[j]),
         .column  (column[j]),
         .bus_out (bus[j+1])
      );
   end

   mvt_sat u_sat (
      .clock   (clock),
      .reset   (reset),
      .bus_in  (bus[mvt_pkg::DIM]),
      .strobe  (rsp_strobe),
      .vout    (vout),
      .clipped (rsp_clipped)
   );

   assign rsp_vout_zero  = vout[0];
   assign rsp_vout_one   = vout[1];
   assign rsp_vout_two   = vout[2];
   assign rsp_vout_three = vout[3];

   // Every accepted transfer yields a result marked by rsp_strobe.
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(mvt_pkg::DIM + 1) rsp_strobe)
      else $error("accepted vector produced no result");

   // No result without a transfer accepted at the matching earlier edge.
   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, mvt_pkg::DIM + 1))
      else $error("result without an accepted vector");

   // A clipped result has at least one component at a saturation limit.
   a_clip_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_clipped) |->
         (rsp_vout_zero == 16'sh7fff || rsp_vout_zero == -16'sh8000 ||
          rsp_vout_one == 16'sh7fff || rsp_vout_one == -16'sh8000 ||
          rsp_vout_two == 16'sh7fff || rsp_vout_two == -16'sh8000 ||
          rsp_vout_three == 16'sh7fff || rsp_vout_three == -16'sh8000))
      else $error("clipped set but no component saturated");

endmodule
